/* design/ffca_pkg.sv */
// ffca_pkg: shared constants for the first-fit contiguous allocator
// no dependencies
package ffca_pkg;

    // slots packed into one memory row
    localparam int ROW_BITS = 8;
    localparam int ROW_SHIFT = 3;

    // request codes
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam int POOL_SIZE_W = 11;
    localparam int LENGTH_W    = 11;
    localparam int SLOT_W      = 10;

    localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RESET = 11'd1024;

endpackage

/* design/first_fit_contiguous_allocator.sv */
// first_fit_contiguous_allocator: first-fit run allocator over a row memory
// depends on ffca_pkg
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    s_req_type, s_length, s_start_slot
//   m_        out        m_valid / m_ready    m_found, m_start_address
//   cfg_      in         cfg_valid/cfg_ready  cfg_pool_size
//
// slot marks live in one memory of 8-slot rows with a registered read
// allocate: accept, then a read and a check per row scanned up to the hit or the pool end,
//   a read and a write per row marked, then load the result; zero length skips scan and marking
// release: accept, then a read and a write per row touched; the row read-modify-write clears the marks
// after reset a clearing pass over every row holds s_ready low
// one request at a time; a waiting result holds the block only at its end
module first_fit_contiguous_allocator #(
    parameter int POOL_SLOTS = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic [ffca_pkg::LENGTH_W-1:0]      s_length,
    input  logic [ffca_pkg::SLOT_W-1:0]        s_start_slot,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_found,
    output logic [ffca_pkg::SLOT_W-1:0]        m_start_address,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ffca_pkg::POOL_SIZE_W-1:0]   cfg_pool_size
);

    localparam int ROWS = (POOL_SLOTS + ffca_pkg::ROW_BITS - 1) / ffca_pkg::ROW_BITS;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW   = ($clog2(POOL_SLOTS + 1) > 12) ? $clog2(POOL_SLOTS + 1) : 12;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_SRD  = 3'd2;
    localparam logic [2:0] ST_SCHK = 3'd3;
    localparam logic [2:0] ST_MRD  = 3'd4;
    localparam logic [2:0] ST_MWR  = 3'd5;
    localparam logic [2:0] ST_RES  = 3'd6;

    // slot mark memory, one bit per slot, 1 = used
    logic [ffca_pkg::ROW_BITS-1:0] mem [ROWS];
    logic [ffca_pkg::ROW_BITS-1:0] mem_rd_reg;
    logic [RW-1:0]                 mem_addr;
    logic                          mem_we;
    logic [ffca_pkg::ROW_BITS-1:0] mem_wd;

    logic [2:0]  state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [SW-1:0] run_reg, run_next;
    logic [SW-1:0] len_reg, len_next;
    logic [SW-1:0] lo_reg, lo_next;
    logic [SW-1:0] hi_reg, hi_next;
    logic        set_reg, set_next;
    logic        alloc_reg, alloc_next;
    logic        found_reg, found_next;
    logic [ffca_pkg::SLOT_W-1:0] addr_reg, addr_next;
    logic        m_valid_reg, m_valid_next;
    logic        m_found_reg, m_found_next;
    logic [ffca_pkg::SLOT_W-1:0] m_start_reg, m_start_next;
    logic [ffca_pkg::POOL_SIZE_W-1:0] pool_size_reg, pool_size_next;

    // scan and mark helpers
    logic [SW-1:0] size;
    logic [SW-1:0] row_base;
    logic [SW-1:0] slot;
    logic [SW-1:0] run_scan;
    logic          hit;
    logic          stop;
    logic [SW-1:0] hit_slot;
    logic [ffca_pkg::ROW_BITS-1:0] mask;
    logic [SW-1:0] rel_end;
    logic [SW-1:0] rel_hi;
    logic [SW-1:0] first;
    logic [RW-1:0] last_row;

    assign s_ready         = (state_reg == ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_start_address = m_start_reg;

    // effective pool size saturates at the physical slot count
    assign size = (SW'(pool_size_reg) > SW'(POOL_SLOTS)) ? SW'(POOL_SLOTS)
                                                         : SW'(pool_size_reg);
    assign row_base = SW'(row_reg) << ffca_pkg::ROW_SHIFT;
    assign rel_end  = SW'(s_start_slot) + SW'(s_length);
    assign rel_hi   = (rel_end > size) ? size : rel_end;
    assign first    = hit_slot + SW'(1) - len_reg;
    assign last_row = RW'((hi_reg - SW'(1)) >> ffca_pkg::ROW_SHIFT);

    // run search over the 8 slots of the row just read
    always_comb begin
        run_scan = run_reg;
        hit      = 1'b0;
        stop     = 1'b0;
        hit_slot = '0;
        slot     = '0;
        for (int b = 0; b < ffca_pkg::ROW_BITS; b++) begin
            slot = row_base + SW'(b);
            if (!hit && !stop) begin
                if (slot >= size) begin
                    stop = 1'b1;
                end else if (mem_rd_reg[b]) begin
                    run_scan = '0;
                end else begin
                    run_scan = run_scan + SW'(1);
                    if (run_scan == len_reg) begin
                        hit      = 1'b1;
                        hit_slot = slot;
                    end
                end
            end
        end
    end

    // bits of the current row inside [lo, hi)
    always_comb begin
        for (int b = 0; b < ffca_pkg::ROW_BITS; b++) begin
            mask[b] = ((row_base + SW'(b)) >= lo_reg) && ((row_base + SW'(b)) < hi_reg);
        end
    end

    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        run_next       = run_reg;
        len_next       = len_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        set_next       = set_reg;
        alloc_next     = alloc_reg;
        found_next     = found_reg;
        addr_next      = addr_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_found_next   = m_found_reg;
        m_start_next   = m_start_reg;
        pool_size_next = cfg_valid ? cfg_pool_size : pool_size_reg;
        mem_addr       = row_reg;
        mem_we         = 1'b0;
        mem_wd         = '0;

        unique case (state_reg)
            ST_CLR: begin
                // clear every row after reset
                mem_we = 1'b1;
                if (row_reg == RW'(ROWS - 1)) begin
                    state_next = ST_IDLE;
                    row_next   = '0;
                end else begin
                    row_next = row_reg + RW'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    alloc_next = (s_req_type == ffca_pkg::REQ_ALLOC);
                    if (s_req_type == ffca_pkg::REQ_ALLOC) begin
                        if (s_length == '0) begin
                            found_next = 1'b1;
                            addr_next  = '0;
                            state_next = ST_RES;
                        end else begin
                            len_next   = SW'(s_length);
                            run_next   = '0;
                            row_next   = '0;
                            state_next = ST_SRD;
                        end
                    end else if (SW'(s_start_slot) < rel_hi) begin
                        // release clipped to the pool
                        lo_next    = SW'(s_start_slot);
                        hi_next    = rel_hi;
                        set_next   = 1'b0;
                        row_next   = RW'(SW'(s_start_slot) >> ffca_pkg::ROW_SHIFT);
                        state_next = ST_MRD;
                    end
                end
            end
            ST_SRD: begin
                state_next = ST_SCHK;
            end
            ST_SCHK: begin
                if (hit) begin
                    lo_next    = first;
                    hi_next    = hit_slot + SW'(1);
                    set_next   = 1'b1;
                    found_next = 1'b1;
                    addr_next  = first[ffca_pkg::SLOT_W-1:0];
                    row_next   = RW'(first >> ffca_pkg::ROW_SHIFT);
                    state_next = ST_MRD;
                end else if (stop || (row_base + SW'(ffca_pkg::ROW_BITS) >= size)) begin
                    // pool end reached inside or at the end of this row
                    found_next = 1'b0;
                    addr_next  = '0;
                    state_next = ST_RES;
                end else begin
                    run_next   = run_scan;
                    row_next   = row_reg + RW'(1);
                    state_next = ST_SRD;
                end
            end
            ST_MRD: begin
                state_next = ST_MWR;
            end
            ST_MWR: begin
                // read-modify-write of one row
                mem_we = 1'b1;
                mem_wd = set_reg ? (mem_rd_reg | mask) : (mem_rd_reg & ~mask);
                if (row_reg == last_row) begin
                    state_next = alloc_reg ? ST_RES : ST_IDLE;
                end else begin
                    row_next   = row_reg + RW'(1);
                    state_next = ST_MRD;
                end
            end
            ST_RES: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_start_next = addr_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        mem_rd_reg <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            row_reg       <= '0;
            m_valid_reg   <= 1'b0;
            pool_size_reg <= ffca_pkg::POOL_SIZE_RESET;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            m_valid_reg   <= m_valid_next;
            pool_size_reg <= pool_size_next;
        end
        run_reg     <= run_next;
        len_reg     <= len_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        set_reg     <= set_next;
        alloc_reg   <= alloc_next;
        found_reg   <= found_next;
        addr_reg    <= addr_next;
        m_found_reg <= m_found_next;
        m_start_reg <= m_start_next;
    end

endmodule

/* tb/sv/tb_first_fit_contiguous_allocator.sv */
// tb_first_fit_contiguous_allocator: self-checking bench for the first-fit run allocator
// depends on ffca_pkg and first_fit_contiguous_allocator
// predicts every allocate result from its own copy of the slot map and pool size
module tb_first_fit_contiguous_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 1024;
    localparam int SETTLE_CYC  = 700;    // longest request walk plus margin
    localparam int STALL_LIMIT = 20000;  // cycles with no handshake at all

    typedef struct {
        logic                        found;
        logic [ffca_pkg::SLOT_W-1:0] start_address;
        int                          len;
    } grant_t;

    typedef struct {
        int first;
        int len;
    } run_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic                             s_req_type;
    logic [ffca_pkg::LENGTH_W-1:0]    s_length;
    logic [ffca_pkg::SLOT_W-1:0]      s_start_slot;
    logic                             m_valid;
    logic                             m_ready;
    logic                             m_found;
    logic [ffca_pkg::SLOT_W-1:0]      m_start_address;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [ffca_pkg::POOL_SIZE_W-1:0] cfg_pool_size;

    // predictor state
    bit                               slot_taken[SLOTS];
    logic [ffca_pkg::POOL_SIZE_W-1:0] pool_limit;
    grant_t                           pending_grants[$];
    run_t                             held_runs[$];

    int  errors;
    int  requests_sent;
    int  grants_checked;
    int  grants_missed;
    int  cfg_writes;
    int  quiet_cycles;
    bit  no_idle;

    first_fit_contiguous_allocator #(.POOL_SLOTS(SLOTS)) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_length       (s_length),
        .s_start_slot   (s_start_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_start_address(m_start_address),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_pool_size  (cfg_pool_size)
    );

    // 10 ns clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // first-fit prediction on one accepted request
    function automatic void predict_request(logic req, int len, int first);
        int  span;
        int  last;
        int  run;
        int  at;
        grant_t g;
        span = (pool_limit > SLOTS) ? SLOTS : int'(pool_limit);
        if (req == ffca_pkg::REQ_RELEASE) begin
            // freed range clipped to the pool, start past the pool frees nothing
            last = first + len;
            if (last > span) last = span;
            for (int i = first; i < last; i++) slot_taken[i] = 1'b0;
            return;
        end
        g.found = 1'b0;
        g.start_address = '0;
        g.len = len;
        if (len == 0) begin
            // zero-length allocate always succeeds at slot 0
            g.found = 1'b1;
        end else begin
            run = 0;
            for (int i = 0; i < span; i++) begin
                if (slot_taken[i]) begin
                    run = 0;
                end else begin
                    run++;
                    if (run == len) begin
                        for (int j = i + 1 - len; j <= i; j++) slot_taken[j] = 1'b1;
                        at = i + 1 - len;
                        g.found = 1'b1;
                        g.start_address = at[ffca_pkg::SLOT_W-1:0];
                        break;
                    end
                end
            end
        end
        pending_grants.push_back(g);
    endfunction

    // monitor: requests, config writes and results, all sampled at the rising edge
    always @(posedge aclk) begin
        grant_t g;
        run_t   r;
        if (aresetn) begin
            if (s_valid && s_ready)
                predict_request(s_req_type, int'(s_length), int'(s_start_slot));
            if (cfg_valid && cfg_ready)
                pool_limit <= cfg_pool_size;
            if (m_valid && m_ready) begin
                if (pending_grants.size() == 0) begin
                    $display("%0t: unexpected result found=%0b start=%0d",
                             $time, m_found, m_start_address);
                    errors++;
                end else begin
                    g = pending_grants.pop_front();
                    grants_checked++;
                    if (m_found !== g.found) begin
                        $display("%0t: found expected %0b actual %0b (len %0d)",
                                 $time, g.found, m_found, g.len);
                        errors++;
                    end
                    if (m_start_address !== g.start_address) begin
                        $display("%0t: start_address expected %0d actual %0d (len %0d)",
                                 $time, g.start_address, m_start_address, g.len);
                        errors++;
                    end
                    if (!g.found) grants_missed++;
                    // remember live runs so releases can hand them back
                    if (g.found && g.len > 0) begin
                        r.first = int'(g.start_address);
                        r.len = g.len;
                        held_runs.push_back(r);
                    end
                end
            end
        end
    end

    // watchdog: any handshake resets the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, pending_grants.size());
                $display("FAIL first_fit_contiguous_allocator");
                $finish;
            end
        end
    end

    // result back-pressure, off during the no-idle stretch
    always @(negedge aclk) begin
        m_ready = no_idle || ($urandom_range(99) >= 38);
    end

    // one request on the input channel, with a random gap in front
    task automatic send_request(logic req, int len, int first);
        if (!no_idle && $urandom_range(99) < 38) begin
            s_valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge aclk);
        end
        s_req_type   = req;
        s_length     = len[ffca_pkg::LENGTH_W-1:0];
        s_start_slot = first[ffca_pkg::SLOT_W-1:0];
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // drain, let any release finish, then write the pool size
    task automatic set_pool_size(int value);
        while (pending_grants.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
        cfg_pool_size = value[ffca_pkg::POOL_SIZE_W-1:0];
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
        // the pool is now whatever survived; forget every held run
        held_runs.delete();
    endtask

    // release a live run, or allocate if none is held
    task automatic free_held_run();
        int k;
        run_t r;
        if (held_runs.size() == 0) begin
            send_request(ffca_pkg::REQ_ALLOC, $urandom_range(8, 1), 0);
        end else begin
            k = $urandom_range(held_runs.size() - 1);
            r = held_runs[k];
            held_runs.delete(k);
            send_request(ffca_pkg::REQ_RELEASE, r.len, r.first);
        end
    endtask

    function automatic int pick_alloc_len();
        int p;
        p = $urandom_range(99);
        if (p < 70) return $urandom_range(16, 1);
        if (p < 95) return $urandom_range(200, 1);
        if (p < 98) return $urandom_range(SLOTS, 0);
        return $urandom_range(2047, 0);
    endfunction

    // extremes of the fields and every special case at full pool
    task automatic test_directed();
        send_request(ffca_pkg::REQ_ALLOC, 0, 0);           // zero-length allocate
        send_request(ffca_pkg::REQ_ALLOC, SLOTS, 1023);    // whole pool
        send_request(ffca_pkg::REQ_ALLOC, 1, 0);           // pool full, must fail
        send_request(ffca_pkg::REQ_RELEASE, 1, 1023);      // last slot
        send_request(ffca_pkg::REQ_ALLOC, 2, 0);           // only one free, fails
        send_request(ffca_pkg::REQ_ALLOC, 1, 0);           // lands on slot 1023
        send_request(ffca_pkg::REQ_RELEASE, 0, 5);         // zero-length release
        send_request(ffca_pkg::REQ_RELEASE, 2047, 0);      // clipped release frees everything
        send_request(ffca_pkg::REQ_ALLOC, 2047, 0);        // longer than any pool
        send_request(ffca_pkg::REQ_ALLOC, 3, 0);
        send_request(ffca_pkg::REQ_ALLOC, 5, 0);
        send_request(ffca_pkg::REQ_RELEASE, 3, 0);         // hole at the front
        send_request(ffca_pkg::REQ_ALLOC, 4, 0);           // too big for the hole
        send_request(ffca_pkg::REQ_ALLOC, 3, 0);           // fits the hole
        send_request(ffca_pkg::REQ_RELEASE, 1024, 1020);   // clipped at the top
        send_request(ffca_pkg::REQ_ALLOC, 1017, 0);        // longer than the free tail, fails
        send_request(ffca_pkg::REQ_RELEASE, 2047, 0);
    endtask

    // mostly alloc/free traffic with some noise releases
    task automatic test_random_traffic(int count);
        int p;
        for (int n = 0; n < count; n++) begin
            p = $urandom_range(99);
            if (p < 55)
                send_request(ffca_pkg::REQ_ALLOC, pick_alloc_len(), $urandom_range(1023));
            else if (p < 90)
                free_held_run();
            else
                send_request(ffca_pkg::REQ_RELEASE, $urandom_range(2047),
                             $urandom_range(1023));
        end
    endtask

    // several pool sizes, extremes included, with probes past the edge
    task automatic test_pool_sizes();
        int sizes[6] = '{2047, 0, 1, 37, 300, 1024};
        foreach (sizes[i]) begin
            set_pool_size(sizes[i]);
            send_request(ffca_pkg::REQ_ALLOC, 1, 0);
            send_request(ffca_pkg::REQ_RELEASE, 5, 1023);             // start past small pools
            send_request(ffca_pkg::REQ_ALLOC, sizes[i] > SLOTS ? SLOTS : sizes[i], 0);
            send_request(ffca_pkg::REQ_RELEASE, 2047, 0);
            test_random_traffic(55);
        end
    endtask

    initial begin
        int wait_cyc;
        errors = 0;
        requests_sent = 0;
        grants_checked = 0;
        grants_missed = 0;
        cfg_writes = 0;
        quiet_cycles = 0;
        no_idle = 1'b0;
        pool_limit = ffca_pkg::POOL_SIZE_RESET;
        foreach (slot_taken[i]) slot_taken[i] = 1'b0;
        s_valid = 1'b0;
        s_req_type = ffca_pkg::REQ_ALLOC;
        s_length = '0;
        s_start_slot = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_pool_size = ffca_pkg::POOL_SIZE_RESET;
        aresetn = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_traffic(80);
        // stretch with no idling on either side
        no_idle = 1'b1;
        test_random_traffic(70);
        no_idle = 1'b0;
        test_pool_sizes();

        // drain, bounded
        wait_cyc = 0;
        while (pending_grants.size() != 0 && wait_cyc < 50 * STALL_LIMIT) begin
            @(negedge aclk);
            wait_cyc++;
        end
        repeat (SETTLE_CYC) @(negedge aclk);
        if (pending_grants.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_grants.size());
            errors++;
        end

        $display("covered %0d requests, %0d allocate results (%0d failed), %0d pool writes",
                 requests_sent, grants_checked, grants_missed, cfg_writes);
        if (errors == 0) begin
            $display("PASS first_fit_contiguous_allocator");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL first_fit_contiguous_allocator");
        end
        $finish;
    end

endmodule
